@@ hw/rtl/smt_pkg.sv @@
`timescale 1ns / 1ps

package smt_pkg;

	localparam int MAX_DIM = 4096;
	localparam int MAX_NNZ = 16384;

	localparam int DIM_W = $clog2(MAX_DIM);         // column / row index
	localparam int NC_W  = $clog2(MAX_DIM + 1);     // column count, start table address
	localparam int NNZ_W = $clog2(MAX_NNZ);         // entry store address
	localparam int CNT_W = $clog2(MAX_NNZ + 1);     // entry count, column start
	localparam int VAL_W = 64;
	localparam int FN_W  = 3;
	localparam int ST_W  = 3;

	localparam int LD_W = VAL_W + 2 * DIM_W;        // {value, col, row}
	localparam int PL_W = VAL_W + DIM_W;            // {value, row}

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 96;

	localparam logic [FN_W-1:0] FN_LOAD    = 3'd0;
	localparam logic [FN_W-1:0] FN_CONVERT = 3'd1;
	localparam logic [FN_W-1:0] FN_READ_PL = 3'd2;
	localparam logic [FN_W-1:0] FN_READ_ST = 3'd3;
	localparam logic [FN_W-1:0] FN_CLEAR   = 3'd4;

	localparam logic [ST_W-1:0] STAT_OK    = 3'd0;
	localparam logic [ST_W-1:0] STAT_FULL  = 3'd1;
	localparam logic [ST_W-1:0] STAT_COL   = 3'd2;
	localparam logic [ST_W-1:0] STAT_PHASE = 3'd3;
	localparam logic [ST_W-1:0] STAT_SLOT  = 3'd4;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DEC,
		S_LOAD_W,
		S_PFX,
		S_PLACE_A,
		S_PLACE_B,
		S_PLACE_C,
		S_RD_W,
		S_RESP
	} state_t;

endpackage

@@ hw/rtl/smt_ram.sv @@
`timescale 1ns / 1ps

module smt_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/sparse_matrix_transpose_core.sv @@
`timescale 1ns / 1ps
// Load and read: decode, one memory step, then the response step registers the result;
// errors go from decode to the response step. Convert (num_cols clamped to 4096) walks
// the column counts into start offsets, then places each entry in steps PLACE_A,
// PLACE_B and PLACE_C. Clear answers, then a pass zeroes all 4096 column counts. One
// command at a time; one result may wait in the output register, the next holds the
// block in its response step. Reset (arst_n low) runs the same pass before any transfer.
module sparse_matrix_transpose_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [12:0]                         cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// row_index[11:0], col_index[23:12], value_bits[87:24], slot[102:88]
	input  logic [smt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// func[2:0]
	input  logic [smt_pkg::FN_W-1:0]            s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_row[11:0], out_value[75:12], out_start[90:76]
	output logic [smt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// status[2:0]
	output logic [smt_pkg::ST_W-1:0]            m_axis_tuser
);

	localparam int DIM_W = smt_pkg::DIM_W;
	localparam int NC_W  = smt_pkg::NC_W;
	localparam int NNZ_W = smt_pkg::NNZ_W;
	localparam int CNT_W = smt_pkg::CNT_W;
	localparam int VAL_W = smt_pkg::VAL_W;

	smt_pkg::state_t state_q, state_d;

	logic [12:0]              num_cols_q;
	logic [NC_W-1:0]          nc;
	logic [NC_W-1:0]          conv_cols_q;
	logic [CNT_W-1:0]         total_q;
	logic                     conv_q;
	logic                     any_q;
	logic [DIM_W-1:0]         max_col_q;
	logic [DIM_W-1:0]         clr_idx_q;

	logic [smt_pkg::FN_W-1:0] func_q;
	logic [DIM_W-1:0]         row_q;
	logic [DIM_W-1:0]         col_q;
	logic [VAL_W-1:0]         val_q;
	logic [14:0]              slot_q;

	logic [smt_pkg::ST_W-1:0] res_status_q, dec_status;
	logic [CNT_W-1:0]         res_start_q;

	logic [NC_W-1:0]          pfx_idx_q;
	logic [DIM_W-1:0]         pfx_c_s1;
	logic                     pfx_v_s1;
	logic [CNT_W-1:0]         acc_q;
	logic [CNT_W-1:0]         ent_q;

	logic                     m_valid_q;
	logic [smt_pkg::OUT_DATA_W-1:0] m_data_q;
	logic [smt_pkg::ST_W-1:0] m_user_q;

	logic                     cnt_we, cnt_re;
	logic [DIM_W-1:0]         cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0]         cnt_wdata, cnt_rdata;
	logic                     st_we, st_re;
	logic [NC_W-1:0]          st_waddr, st_raddr;
	logic [CNT_W-1:0]         st_wdata, st_rdata;
	logic                     ld_we, ld_re;
	logic [NNZ_W-1:0]         ld_waddr, ld_raddr;
	logic [smt_pkg::LD_W-1:0] ld_wdata, ld_rdata;
	logic                     pl_we, pl_re;
	logic [NNZ_W-1:0]         pl_waddr, pl_raddr;
	logic [smt_pkg::PL_W-1:0] pl_wdata, pl_rdata;

	logic                     accept;
	logic                     out_free;
	logic                     pfx_done;
	logic                     load_ok;
	logic                     conv_ok;
	logic                     rd_ok;
	logic                     last_ent;

	assign nc = (num_cols_q > 13'(smt_pkg::MAX_DIM)) ? NC_W'(smt_pkg::MAX_DIM)
	                                                   : NC_W'(num_cols_q);
	assign s_axis_tready = (state_q == smt_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign pfx_done      = (pfx_idx_q == nc) && !pfx_v_s1;
	assign last_ent      = (ent_q + CNT_W'(1)) >= total_q;

	// decode of the held command
	always_comb begin
		dec_status = smt_pkg::STAT_OK;
		load_ok    = 1'b0;
		conv_ok    = 1'b0;
		rd_ok      = 1'b0;
		case (func_q)
			smt_pkg::FN_LOAD: begin
				if (conv_q) begin
					dec_status = smt_pkg::STAT_PHASE;
				end else if ({1'b0, col_q} >= nc) begin
					dec_status = smt_pkg::STAT_COL;
				end else if (total_q == CNT_W'(smt_pkg::MAX_NNZ)) begin
					dec_status = smt_pkg::STAT_FULL;
				end else begin
					load_ok = 1'b1;
				end
			end
			smt_pkg::FN_CONVERT: begin
				if (conv_q) begin
					dec_status = smt_pkg::STAT_PHASE;
				end else if (any_q && ({1'b0, max_col_q} >= nc)) begin
					dec_status = smt_pkg::STAT_COL;
				end else begin
					conv_ok = 1'b1;
				end
			end
			smt_pkg::FN_READ_PL: begin
				if (!conv_q) begin
					dec_status = smt_pkg::STAT_PHASE;
				end else if (slot_q >= total_q) begin
					dec_status = smt_pkg::STAT_SLOT;
				end else begin
					rd_ok = 1'b1;
				end
			end
			smt_pkg::FN_READ_ST: begin
				if (!conv_q) begin
					dec_status = smt_pkg::STAT_PHASE;
				end else if (slot_q > {2'b0, conv_cols_q}) begin
					dec_status = smt_pkg::STAT_SLOT;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smt_pkg::S_CLR: begin
				if (clr_idx_q == DIM_W'(smt_pkg::MAX_DIM - 1)) begin
					state_d = smt_pkg::S_IDLE;
				end
			end
			smt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = smt_pkg::S_DEC;
				end
			end
			smt_pkg::S_DEC: begin
				if (load_ok) begin
					state_d = smt_pkg::S_LOAD_W;
				end else if (conv_ok) begin
					state_d = smt_pkg::S_PFX;
				end else if (rd_ok) begin
					state_d = smt_pkg::S_RD_W;
				end else begin
					state_d = smt_pkg::S_RESP;
				end
			end
			smt_pkg::S_LOAD_W: state_d = smt_pkg::S_RESP;
			smt_pkg::S_PFX: begin
				if (pfx_done) begin
					state_d = (total_q == '0) ? smt_pkg::S_RESP : smt_pkg::S_PLACE_A;
				end
			end
			smt_pkg::S_PLACE_A: state_d = smt_pkg::S_PLACE_B;
			smt_pkg::S_PLACE_B: state_d = smt_pkg::S_PLACE_C;
			smt_pkg::S_PLACE_C: begin
				state_d = last_ent ? smt_pkg::S_RESP : smt_pkg::S_PLACE_A;
			end
			smt_pkg::S_RD_W: state_d = smt_pkg::S_RESP;
			smt_pkg::S_RESP: begin
				if (out_free) begin
					state_d = (func_q == smt_pkg::FN_CLEAR) ? smt_pkg::S_CLR
					                                        : smt_pkg::S_IDLE;
				end
			end
			default: state_d = smt_pkg::S_CLR;
		endcase
	end

	// memory port controls
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = '0;
		cnt_wdata = '0;
		cnt_re    = 1'b0;
		cnt_raddr = '0;
		st_we     = 1'b0;
		st_waddr  = '0;
		st_wdata  = '0;
		st_re     = 1'b0;
		st_raddr  = slot_q[NC_W-1:0];
		ld_we     = 1'b0;
		ld_waddr  = total_q[NNZ_W-1:0];
		ld_wdata  = {val_q, col_q, row_q};
		ld_re     = 1'b0;
		ld_raddr  = ent_q[NNZ_W-1:0];
		pl_we     = 1'b0;
		pl_waddr  = cnt_rdata[NNZ_W-1:0];
		pl_wdata  = {ld_rdata[smt_pkg::LD_W-1:2*DIM_W], ld_rdata[DIM_W-1:0]};
		pl_re     = 1'b0;
		pl_raddr  = slot_q[NNZ_W-1:0];
		case (state_q)
			smt_pkg::S_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
			end
			smt_pkg::S_DEC: begin
				if (load_ok) begin
					ld_we     = 1'b1;
					cnt_re    = 1'b1;
					cnt_raddr = col_q;
				end
				if (rd_ok) begin
					pl_re = (func_q == smt_pkg::FN_READ_PL);
					st_re = (func_q == smt_pkg::FN_READ_ST);
				end
			end
			smt_pkg::S_LOAD_W: begin
				cnt_we    = 1'b1;
				cnt_waddr = col_q;
				cnt_wdata = cnt_rdata + CNT_W'(1);
			end
			smt_pkg::S_PFX: begin
				cnt_re    = (pfx_idx_q < nc);
				cnt_raddr = pfx_idx_q[DIM_W-1:0];
				if (pfx_v_s1) begin
					// count becomes the insertion cursor
					cnt_we    = 1'b1;
					cnt_waddr = pfx_c_s1;
					cnt_wdata = acc_q;
					st_we     = 1'b1;
					st_waddr  = NC_W'(pfx_c_s1) + NC_W'(1);
					st_wdata  = acc_q + cnt_rdata;
				end else if (pfx_idx_q == '0) begin
					st_we = 1'b1;
				end
			end
			smt_pkg::S_PLACE_A: ld_re = 1'b1;
			smt_pkg::S_PLACE_B: begin
				cnt_re    = 1'b1;
				cnt_raddr = ld_rdata[2*DIM_W-1:DIM_W];
			end
			smt_pkg::S_PLACE_C: begin
				cnt_we    = 1'b1;
				cnt_waddr = ld_rdata[2*DIM_W-1:DIM_W];
				cnt_wdata = cnt_rdata + CNT_W'(1);
				pl_we     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= smt_pkg::S_CLR;
			num_cols_q   <= 13'(smt_pkg::MAX_DIM);
			conv_cols_q  <= '0;
			total_q      <= '0;
			conv_q       <= 1'b0;
			any_q        <= 1'b0;
			max_col_q    <= '0;
			clr_idx_q    <= '0;
			pfx_v_s1     <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				num_cols_q <= cfg_wdata;
			end
			if (state_q == smt_pkg::S_CLR) begin
				clr_idx_q <= clr_idx_q + DIM_W'(1);
			end
			if (state_q == smt_pkg::S_DEC && func_q == smt_pkg::FN_CLEAR) begin
				total_q   <= '0;
				conv_q    <= 1'b0;
				any_q     <= 1'b0;
				clr_idx_q <= '0;
			end
			if (state_q == smt_pkg::S_LOAD_W) begin
				total_q <= total_q + CNT_W'(1);
				any_q   <= 1'b1;
				if (!any_q || col_q > max_col_q) begin
					max_col_q <= col_q;
				end
			end
			pfx_v_s1 <= (state_q == smt_pkg::S_PFX) && (pfx_idx_q < nc);
			if ((state_q == smt_pkg::S_PFX && pfx_done && total_q == '0) ||
			    (state_q == smt_pkg::S_PLACE_C && last_ent)) begin
				conv_q      <= 1'b1;
				conv_cols_q <= nc;
			end
			m_valid_q <= (state_q == smt_pkg::S_RESP && out_free) ||
			             (m_valid_q && !m_axis_tready);
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_axis_tuser;
			row_q  <= s_axis_tdata[11:0];
			col_q  <= s_axis_tdata[23:12];
			val_q  <= s_axis_tdata[87:24];
			slot_q <= s_axis_tdata[102:88];
		end
		if (state_q == smt_pkg::S_DEC) begin
			res_status_q <= dec_status;
			res_start_q  <= '0;
			pfx_idx_q    <= '0;
			acc_q        <= '0;
			ent_q        <= '0;
		end
		if (state_q == smt_pkg::S_PFX) begin
			if (pfx_idx_q < nc) begin
				pfx_idx_q <= pfx_idx_q + NC_W'(1);
			end
			pfx_c_s1 <= pfx_idx_q[DIM_W-1:0];
			if (pfx_v_s1) begin
				acc_q <= acc_q + cnt_rdata;
			end
			res_start_q <= total_q;
		end
		if (state_q == smt_pkg::S_PLACE_C) begin
			ent_q <= ent_q + CNT_W'(1);
		end
		if (state_q == smt_pkg::S_RESP && out_free) begin
			m_user_q <= res_status_q;
			if (res_status_q == smt_pkg::STAT_OK) begin
				case (func_q)
					smt_pkg::FN_READ_PL: begin
						m_data_q <= {20'b0, pl_rdata[smt_pkg::PL_W-1:DIM_W],
						             pl_rdata[DIM_W-1:0]};
					end
					smt_pkg::FN_READ_ST: m_data_q <= {5'b0, st_rdata, 76'b0};
					smt_pkg::FN_CONVERT: m_data_q <= {5'b0, res_start_q, 76'b0};
					default: m_data_q <= '0;
				endcase
			end else begin
				m_data_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	smt_ram #(.DEPTH(smt_pkg::MAX_DIM), .WIDTH(CNT_W)) u_count (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	smt_ram #(.DEPTH(smt_pkg::MAX_DIM + 1), .WIDTH(CNT_W)) u_start (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.re(st_re), .raddr(st_raddr), .rdata(st_rdata)
	);

	smt_ram #(.DEPTH(smt_pkg::MAX_NNZ), .WIDTH(smt_pkg::LD_W)) u_loaded (
		.clk(clk), .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
		.re(ld_re), .raddr(ld_raddr), .rdata(ld_rdata)
	);

	smt_ram #(.DEPTH(smt_pkg::MAX_NNZ), .WIDTH(smt_pkg::PL_W)) u_placed (
		.clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
		.re(pl_re), .raddr(pl_raddr), .rdata(pl_rdata)
	);

endmodule
